// ----- sv/bgse_pkg.sv -----
// ----------------------------------------------------------------------------
// bgse_pkg: shared types and constants of the BGR gray Sobel edge stream
// Pixel and result payloads, configuration register codes, queue job format
// and the fixed-point weights of the gray conversion.
// ----------------------------------------------------------------------------
package bgse_pkg;

    // Sizes and defaults
    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_HEIGHT      = 2048;
    localparam int FRAME_SIZE_MIN  = 3;

    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

    // Q16 luma weights, summing to 65536
    localparam logic [23:0] W_BLUE  = 24'd7471;
    localparam logic [23:0] W_GREEN = 24'd38470;
    localparam logic [23:0] W_RED   = 24'd19595;

    localparam logic [7:0] MAG_MAX = 8'd255;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix_in;

    typedef struct packed {
        logic [10:0] out_row;
        logic [10:0] out_column;
        logic [7:0]  edge_res;
    } t_pix_out;

    // Classified pixel as it travels through the queue
    typedef struct packed {
        logic [10:0] out_row;
        logic [10:0] out_column;
        logic        emit;
        logic        border;
        logic [7:0]  gray;
    } t_job;

endpackage

// ----- sv/bgse_ram.sv -----
// ----------------------------------------------------------------------------
// bgse_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data, read-first.
// ----------------------------------------------------------------------------
module bgse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bgse_front.sv -----
// ----------------------------------------------------------------------------
// bgse_front: pixel intake and classification
// Tracks the raster position, decides whether and where a result is due,
// and forms the gray value before handing the job to the queue.
// ----------------------------------------------------------------------------
module bgse_front #(
    parameter int MAX_WIDTH = bgse_pkg::MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int WW = AW + 1,
    localparam int JW = $bits(bgse_pkg::t_job) + AW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgse_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_stall,
    input  bgse_pkg::t_pix_in i_data,
    output logic              o_push,
    output logic [JW-1:0]     o_push_data,
    input  logic              i_q_full
);

    logic              r_f1_valid;
    logic [AW-1:0]     r_f1_addr;
    logic [10:0]       r_f1_row;
    logic [10:0]       r_f1_col;
    logic              r_f1_emit;
    logic              r_f1_border;
    logic [23:0]       r_f1_pb;
    logic [23:0]       r_f1_pg;
    logic [23:0]       r_f1_pr;
    logic [AW-1:0]     r_col;
    logic [10:0]       r_row;

    logic              f_en;
    logic              accept;
    logic [WW-1:0]     w_lim;
    logic [11:0]       h_lim;
    logic [WW-1:0]     col0;
    logic [11:0]       row0;
    logic [AW-1:0]     cur_c;
    logic [10:0]       cur_r;
    logic [WW-1:0]     c_inc;
    logic [11:0]       r_inc;
    logic [AW-1:0]     n_col;
    logic [10:0]       n_row;
    logic [23:0]       luma;
    bgse_pkg::t_job    job;

    assign f_en    = !r_f1_valid || !i_q_full;
    assign o_stall = !f_en;
    assign accept  = i_valid && f_en;

    // Hold the frame size within its legal range
    always_comb begin
        if (32'(i_cfg.frame_width) > 32'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else if (32'(i_cfg.frame_width) < 32'(bgse_pkg::FRAME_SIZE_MIN)) begin
            w_lim = WW'(bgse_pkg::FRAME_SIZE_MIN);
        end else begin
            w_lim = WW'(i_cfg.frame_width);
        end
        if (32'(i_cfg.frame_height) > 32'(bgse_pkg::MAX_HEIGHT)) begin
            h_lim = 12'(bgse_pkg::MAX_HEIGHT);
        end else if (32'(i_cfg.frame_height) < 32'(bgse_pkg::FRAME_SIZE_MIN)) begin
            h_lim = 12'(bgse_pkg::FRAME_SIZE_MIN);
        end else begin
            h_lim = i_cfg.frame_height;
        end
    end

    // Place this pixel, then advance the position for the next one
    always_comb begin
        col0 = i_data.frame_start ? '0 : {1'b0, r_col};
        row0 = i_data.frame_start ? '0 : {1'b0, r_row};
        if (col0 >= w_lim) begin
            col0 = '0;
            row0 = row0 + 12'd1;
        end
        if (row0 >= h_lim) begin
            row0 = '0;
        end
        cur_c = col0[AW-1:0];
        cur_r = row0[10:0];
        c_inc = {1'b0, cur_c} + WW'(1);
        r_inc = {1'b0, cur_r} + 12'd1;
        if (c_inc >= w_lim) begin
            n_col = '0;
            n_row = (r_inc >= h_lim) ? '0 : r_inc[10:0];
        end else begin
            n_col = c_inc[AW-1:0];
            n_row = cur_r;
        end
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Intake stage: classification and weighted products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (f_en) begin
            r_f1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_addr   <= cur_c;
            r_f1_row    <= cur_r - 11'd1;
            r_f1_col    <= 11'(cur_c - AW'(1));
            r_f1_emit   <= (cur_r != '0) && (cur_c != '0);
            r_f1_border <= (cur_r == 11'd1) || (cur_c == AW'(1));
            r_f1_pb     <= bgse_pkg::W_BLUE  * 24'(i_data.blue);
            r_f1_pg     <= bgse_pkg::W_GREEN * 24'(i_data.green);
            r_f1_pr     <= bgse_pkg::W_RED   * 24'(i_data.red);
        end
    end

    // Sum the products into gray and transfer the job to the queue
    always_comb begin
        luma           = r_f1_pb + r_f1_pg + r_f1_pr;
        job.out_row    = r_f1_row;
        job.out_column = r_f1_col;
        job.emit       = r_f1_emit;
        job.border     = r_f1_border;
        job.gray       = luma[23:16];
    end

    assign o_push      = r_f1_valid && !i_q_full;
    assign o_push_data = {r_f1_addr, job};

endmodule

// ----- sv/bgse_fifo.sv -----
// ----------------------------------------------------------------------------
// bgse_fifo: job queue between the front and the back
// Small register queue so that intake and the window pipeline stall apart.
// ----------------------------------------------------------------------------
module bgse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bgse_pkg::QUEUE_DEPTH_DEF,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- sv/bgse_back.sv -----
// ----------------------------------------------------------------------------
// bgse_back: line stores, 3x3 window and Sobel magnitude
// Reads and rewrites both line stores per pixel, shifts the window and
// produces the saturated L1 gradient into the output register.
// ----------------------------------------------------------------------------
module bgse_back #(
    parameter int MAX_WIDTH = bgse_pkg::MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int JW = $bits(bgse_pkg::t_job) + AW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [JW-1:0]      i_q_head,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output bgse_pkg::t_pix_out o_data
);

    logic               b_en;
    logic               pop;
    logic [AW-1:0]      head_addr;
    bgse_pkg::t_job     head_job;

    logic               r_b1_valid;
    logic [AW-1:0]      r_b1_addr;
    bgse_pkg::t_job     r_b1_job;
    logic               r_byp;
    logic [7:0]         r_byp_top;
    logic [7:0]         r_byp_mid;
    logic [7:0]         two_q;
    logic [7:0]         one_q;
    logic [7:0]         cur_top;
    logic [7:0]         cur_mid;

    logic [7:0]         r_win [3][3];
    logic               r_b2_valid;
    bgse_pkg::t_job     r_b2_job;
    logic               r_b3_valid;
    bgse_pkg::t_job     r_b3_job;
    logic signed [10:0] r_gx;
    logic signed [10:0] r_gy;

    logic [9:0]         sx_p;
    logic [9:0]         sx_n;
    logic [9:0]         sy_p;
    logic [9:0]         sy_n;
    logic [9:0]         ax;
    logic [9:0]         ay;
    logic [10:0]        mag;
    logic [7:0]         mag_sat;

    logic               r_out_valid;
    bgse_pkg::t_pix_out r_out;

    // Whole back pipeline moves whenever the output register can take a result
    assign b_en      = !r_out_valid || !i_stall;
    assign pop       = b_en && !i_q_empty;
    assign o_q_pop   = pop;
    assign head_addr = i_q_head[JW-1 -: AW];
    assign head_job  = bgse_pkg::t_job'(i_q_head[$bits(bgse_pkg::t_job)-1:0]);

    // Line stores: read at pop, rewrite one stage later
    bgse_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_two (
        .i_clk   (i_clk),
        .i_we    (b_en && r_b1_valid),
        .i_waddr (r_b1_addr),
        .i_wdata (cur_mid),
        .i_re    (b_en),
        .i_raddr (head_addr),
        .o_rdata (two_q)
    );

    bgse_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_one (
        .i_clk   (i_clk),
        .i_we    (b_en && r_b1_valid),
        .i_waddr (r_b1_addr),
        .i_wdata (r_b1_job.gray),
        .i_re    (b_en),
        .i_raddr (head_addr),
        .o_rdata (one_q)
    );

    // Forward the write of the previous pixel when it hits the same column
    assign cur_top = r_byp ? r_byp_top : two_q;
    assign cur_mid = r_byp ? r_byp_mid : one_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
        end else if (b_en) begin
            r_b1_valid <= pop;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b1_addr <= head_addr;
            r_b1_job  <= head_job;
            r_byp     <= r_b1_valid && (head_addr == r_b1_addr);
            r_byp_top <= cur_mid;
            r_byp_mid <= r_b1_job.gray;
            r_b2_job  <= r_b1_job;
            r_b3_job  <= r_b2_job;
            r_gx      <= $signed({1'b0, sx_p}) - $signed({1'b0, sx_n});
            r_gy      <= $signed({1'b0, sy_p}) - $signed({1'b0, sy_n});
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (b_en && r_b1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= cur_top;
            r_win[1][2] <= cur_mid;
            r_win[2][2] <= r_b1_job.gray;
        end
    end

    // Gradient partial sums
    always_comb begin
        sx_p = 10'(r_win[0][2]) + {1'b0, r_win[1][2], 1'b0} + 10'(r_win[2][2]);
        sx_n = 10'(r_win[0][0]) + {1'b0, r_win[1][0], 1'b0} + 10'(r_win[2][0]);
        sy_p = 10'(r_win[2][0]) + {1'b0, r_win[2][1], 1'b0} + 10'(r_win[2][2]);
        sy_n = 10'(r_win[0][0]) + {1'b0, r_win[0][1], 1'b0} + 10'(r_win[0][2]);
    end

    // Magnitude with saturation
    always_comb begin
        ax      = r_gx[10] ? 10'(-r_gx) : r_gx[9:0];
        ay      = r_gy[10] ? 10'(-r_gy) : r_gy[9:0];
        mag     = {1'b0, ax} + {1'b0, ay};
        mag_sat = (mag > 11'(bgse_pkg::MAG_MAX)) ? bgse_pkg::MAG_MAX : mag[7:0];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_out_valid <= r_b3_valid && r_b3_job.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_out.out_row    <= r_b3_job.out_row;
            r_out.out_column <= r_b3_job.out_column;
            r_out.edge_res   <= r_b3_job.border ? '0 : mag_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- sv/bgr_gray_sobel_edge_stream.sv -----
// ----------------------------------------------------------------------------
// bgr_gray_sobel_edge_stream: streaming BGR to gray to Sobel edge magnitude
// Configuration registers, intake front, job queue and window back end.
// ----------------------------------------------------------------------------
// Takes one BGR pixel per clock in raster order while o_stall is low and
// returns the saturated |gx|+|gy| Sobel magnitude of the pixel one row up and
// one column left, zero on the frame border; the last row and column are not
// returned. Sustained rate is one pixel per clock when neither side stalls,
// set by the single read-modify-write pass of each line store per pixel. Gray
// uses Q16 weights 7471/38470/19595 with truncation. Write frame_width and
// frame_height only while idle; frame_start restarts the position at row 0,
// column 0 while keeping the line stores.
module bgr_gray_sobel_edge_stream #(
    parameter int MAX_WIDTH   = bgse_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = bgse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  bgse_pkg::t_pix_in  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output bgse_pkg::t_pix_out o_data,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [11:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int JW = $bits(bgse_pkg::t_job) + AW;

    bgse_pkg::t_cfg r_cfg;
    logic           w_push;
    logic [JW-1:0]  w_push_data;
    logic           w_pop;
    logic [JW-1:0]  w_q_head;
    logic           w_q_empty;
    logic           w_q_full;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= bgse_pkg::FRAME_WIDTH_RST;
            r_cfg.frame_height <= bgse_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (bgse_pkg::t_cfg_idx'(i_cfg_idx))
                bgse_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                bgse_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bgse_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_q_full    (w_q_full)
    );

    bgse_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_q_head),
        .o_empty     (w_q_empty),
        .o_full      (w_q_full)
    );

    bgse_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_head  (w_q_head),
        .o_q_pop   (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    // Queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("job pushed into a full queue");

    // Queue never underflows
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_empty))
        else $error("job popped from an empty queue");

    // First row and column of results are always zero
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.out_row == 11'd0 || o_data.out_column == 11'd0))
        |-> (o_data.edge_res == 8'd0))
        else $error("non-zero result on the frame border");

endmodule

// ----- dv/tb_bgr_gray_sobel_edge_stream.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bgr_gray_sobel_edge_stream: self-checking bench for the gray Sobel stream
// Feeds BGR pixels over the valid/stall channel and keeps its own line stores,
// window and position counters to predict each edge result. Every result is
// checked field by field in order. Covers the reset geometry, field extremes,
// clamping of undersized and oversized frames, frame wrap, mid-frame restarts
// and mid-frame shrinks, then random frames under changing idling.
// ----------------------------------------------------------------------------
module tb_bgr_gray_sobel_edge_stream;

    localparam int          RUN_LIMIT_NS = 2_000_000;
    localparam int unsigned LINE_MAX     = 2048;
    localparam int unsigned DIM_MIN      = 3;
    localparam int unsigned DEF_WIDTH    = 640;
    localparam int unsigned DEF_HEIGHT   = 480;
    localparam int unsigned GW_BLUE      = 7471;
    localparam int unsigned GW_GREEN     = 38470;
    localparam int unsigned GW_RED       = 19595;
    localparam int          MAG_CEIL     = 255;
    localparam int          PIPE_SLACK   = 24;
    localparam int          DRAIN_LIMIT  = 4000;
    localparam int          RANDOM_ITEMS = 200;
    localparam int          OVERSIZE_PIX = 40;
    localparam int          PRINT_CAP    = 40;

    logic               i_clk   = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    bgse_pkg::t_pix_in  i_data;
    logic               o_valid;
    logic               i_stall = 1'b0;
    bgse_pkg::t_pix_out o_data;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_idx;
    logic [11:0]        i_cfg_data;

    // Predictor state
    logic [7:0]  gray_two_up [LINE_MAX];
    logic [7:0]  gray_one_up [LINE_MAX];
    logic [7:0]  nbhd [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [11:0] cfg_width;
    logic [11:0] cfg_height;
    logic        restart_due;

    bgse_pkg::t_pix_out pending_edges [$];

    int src_idle_pct;
    int sink_stall_pct;
    int pixels_sent;
    int edges_checked;
    int reg_writes;
    int mismatch_count;

    bgr_gray_sobel_edge_stream DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Randomise the result-side stall at each falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            check_edge(o_data);
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic check_edge(input bgse_pkg::t_pix_out got);
        bgse_pkg::t_pix_out want;
        if (pending_edges.size() == 0) begin
            flag_mismatch($sformatf("unexpected result row %0d col %0d edge %0d",
                                    got.out_row, got.out_column, got.edge_res));
            return;
        end
        want = pending_edges.pop_front();
        edges_checked++;
        if (got.out_row !== want.out_row) begin
            flag_mismatch($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
        end
        if (got.out_column !== want.out_column) begin
            flag_mismatch($sformatf("out_column %0d, expected %0d at row %0d",
                                    got.out_column, want.out_column, want.out_row));
        end
        if (got.edge_res !== want.edge_res) begin
            flag_mismatch($sformatf("edge_res %0d, expected %0d at (%0d,%0d)", got.edge_res,
                                    want.edge_res, want.out_row, want.out_column));
        end
    endtask

    function automatic int unsigned clamp_dim(input logic [11:0] v);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > LINE_MAX) return LINE_MAX;
        return 32'(v);
    endfunction

    // Advance the predicted stream by one pixel and queue any edge result
    task automatic model_pixel(input bgse_pkg::t_pix_in px);
        int unsigned        w, h, r, c, gsum;
        logic [7:0]         gray, top, mid;
        int                 gx, gy, mag, k;
        bgse_pkg::t_pix_out res;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;

        gsum = GW_BLUE * px.blue + GW_GREEN * px.green + GW_RED * px.red;
        gray = 8'(gsum >> 16);

        // Rotate the line stores at this column and shift the window left
        top = gray_two_up[c];
        mid = gray_one_up[c];
        gray_two_up[c] = mid;
        gray_one_up[c] = gray;
        for (k = 0; k < 3; k++) begin
            nbhd[k][0] = nbhd[k][1];
            nbhd[k][1] = nbhd[k][2];
        end
        nbhd[0][2] = top;
        nbhd[1][2] = mid;
        nbhd[2][2] = gray;

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end

        if (r < 1 || c < 1) return;

        if (r == 1 || c == 1) begin
            mag = 0;
        end else begin
            gx = (int'(nbhd[0][2]) + 2 * int'(nbhd[1][2]) + int'(nbhd[2][2]))
               - (int'(nbhd[0][0]) + 2 * int'(nbhd[1][0]) + int'(nbhd[2][0]));
            gy = (int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2]))
               - (int'(nbhd[0][0]) + 2 * int'(nbhd[0][1]) + int'(nbhd[0][2]));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > MAG_CEIL) mag = MAG_CEIL;
        end
        res.out_row    = 11'(r - 1);
        res.out_column = 11'(c - 1);
        res.edge_res   = 8'(mag);
        pending_edges.push_back(res);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin
                src_idle_pct   = 11;
                sink_stall_pct = 61;
            end
            1: begin
                src_idle_pct   = 61;
                sink_stall_pct = 11;
            end
            default: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    // Send one pixel; entered and left at a falling edge
    task automatic push_pixel(input logic fs, input logic [7:0] b, g, r);
        bgse_pkg::t_pix_in px;
        px.frame_start = fs | restart_due;
        px.blue        = b;
        px.green       = g;
        px.red         = r;
        restart_due    = 1'b0;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_data  = px;
        i_valid = 1'b1;
        model_pixel(px);
        pixels_sent++;
        // hold until the transfer takes place
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic push_random(input logic fs);
        push_pixel(fs, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop valid, wait for all queued results, then let the pipeline empty
    task automatic settle();
        int guard;
        i_valid = 1'b0;
        guard   = 0;
        while (pending_edges.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (PIPE_SLACK) @(negedge i_clk);
    endtask

    task automatic write_reg(input bgse_pkg::t_cfg_idx idx, input logic [11:0] value);
        settle();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        reg_writes++;
        if (idx == bgse_pkg::CFG_FRAME_WIDTH) begin
            // a wider row would read columns the rows above never wrote: restart
            if (clamp_dim(value) > clamp_dim(cfg_width)) restart_due = 1'b1;
            cfg_width = value;
        end else begin
            cfg_height = value;
        end
    endtask

    // One row and a little more at the reset geometry, first pixel without frame_start
    task automatic test_reset_geometry();
        int unsigned i;
        set_idling(0);
        for (i = 0; i < DEF_WIDTH + 8; i++) push_random(1'b0);
    endtask

    // 5x5 frame: a flat black corner, then saturated and single-channel swatches
    task automatic test_pixel_extremes();
        int unsigned i, sel;
        logic [23:0] bgr;
        set_idling(0);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd5);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd5);
        for (i = 0; i < 25; i++) begin
            sel = (i < 15 && i % 5 < 3) ? 0 : (i * 5) % 8;
            case (sel)
                0:       bgr = 24'h00_00_00;
                1:       bgr = 24'hff_ff_ff;
                2:       bgr = 24'hff_00_00;
                3:       bgr = 24'h00_ff_00;
                4:       bgr = 24'h00_00_ff;
                5:       bgr = 24'h01_01_01;  // weights sum to exactly one unit
                6:       bgr = 24'hff_ff_00;
                default: bgr = 24'h00_ff_ff;
            endcase
            push_pixel(i == 0, bgr[23:16], bgr[15:8], bgr[7:0]);
        end
    endtask

    // Sizes below the minimum hold at 3; the frame wraps without frame_start
    task automatic test_size_clamps();
        int unsigned i;
        set_idling(1);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd2);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd0);
        for (i = 0; i < 15; i++) push_random(i == 0);
    endtask

    // Width above the line store size holds at 2048: the row must not wrap early
    task automatic test_wide_frame();
        int unsigned i;
        set_idling(1);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd4095);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd3);
        for (i = 0; i < OVERSIZE_PIX; i++) push_random(i == 0);
    endtask

    // Height above 2048 holds at 2048: rows run on past any small wrap
    task automatic test_tall_frame();
        int unsigned i;
        set_idling(2);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd3);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd4095);
        for (i = 0; i < OVERSIZE_PIX; i++) push_random(i == 0);
    endtask

    // frame_start partway through a frame; line stores keep their contents
    task automatic test_restart_mid_frame();
        int unsigned i;
        set_idling(0);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd6);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd5);
        for (i = 0; i < 15; i++) push_random(i == 0);
        for (i = 0; i < 30; i++) push_random(i == 0);
    endtask

    // Shrink width past the current column, then height past the current row
    task automatic test_shrink_mid_frame();
        int unsigned i;
        set_idling(1);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd8);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd6);
        for (i = 0; i < 29; i++) push_random(i == 0);
        write_reg(bgse_pkg::CFG_FRAME_WIDTH, 12'd4);
        for (i = 0; i < 6; i++) push_random(1'b0);
        write_reg(bgse_pkg::CFG_FRAME_HEIGHT, 12'd3);
        for (i = 0; i < 14; i++) push_random(1'b0);
    endtask

    // Mostly whole frames of random content at small sizes, some broken ones
    task automatic test_random_frames();
        int unsigned i, n, cut, area, kind, first_sent, done;
        logic        fs;
        first_sent = pixels_sent;
        done       = 0;
        while (done < RANDOM_ITEMS) begin
            set_idling(done * 3 / RANDOM_ITEMS);
            if ($urandom_range(0, 3) != 0) begin
                write_reg(bgse_pkg::CFG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ?
                          12'($urandom_range(0, 2)) : 12'($urandom_range(3, 12)));
                write_reg(bgse_pkg::CFG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ?
                          12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8)));
            end else if ($urandom_range(0, 1) == 0) begin
                settle();
            end
            area = clamp_dim(cfg_width) * clamp_dim(cfg_height);
            kind = $urandom_range(0, 9);
            cut  = $urandom_range(1, area - 1);
            if (kind <= 6) n = area * $urandom_range(1, 2);
            else if (kind <= 8) n = cut + area;
            else n = $urandom_range(4, 2 * area);
            for (i = 0; i < n; i++) begin
                if (kind == 9) fs = ($urandom_range(0, 7) == 0);
                else fs = (i == 0) || (kind >= 7 && i == cut);
                push_random(fs);
            end
            done = pixels_sent - first_sent;
        end
    endtask

    initial begin
        int k;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = bgse_pkg::CFG_FRAME_WIDTH;
        i_cfg_data     = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        pixels_sent    = 0;
        edges_checked  = 0;
        reg_writes     = 0;
        mismatch_count = 0;
        cfg_width      = 12'(DEF_WIDTH);
        cfg_height     = 12'(DEF_HEIGHT);
        restart_due    = 1'b0;
        row_pos        = 0;
        col_pos        = 0;
        for (k = 0; k < LINE_MAX; k++) begin
            gray_two_up[k] = '0;
            gray_one_up[k] = '0;
        end
        for (k = 0; k < 9; k++) nbhd[k / 3][k % 3] = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_geometry();
        test_pixel_extremes();
        test_size_clamps();
        test_wide_frame();
        test_tall_frame();
        test_restart_mid_frame();
        test_shrink_mid_frame();
        test_random_frames();

        settle();
        if (pending_edges.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_edges.size()));
        end
        $display("Streamed %0d pixels through %0d register writes, %0d edge results checked.",
                 pixels_sent, reg_writes, edges_checked);
        $display("Frames clamped below and above, wraps, restarts, shrinks, idling; %0d %s",
                 mismatch_count, "mismatches.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit: about 1100 pixels take far less time than this
    initial begin
        #(RUN_LIMIT_NS);
        $display("Run limit hit with %0d results outstanding", pending_edges.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
